FILE: sv/bc_pkg.sv
package bc_pkg;

  // Command kinds carried by each request.
  typedef enum logic [1:0] {
    KIND_ABS   = 2'd0,
    KIND_REL   = 2'd1,
    KIND_MOVE  = 2'd2,
    KIND_OTHER = 2'd3
  } kind_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_X_OFF = 2'd0,
    CFG_Y_OFF = 2'd1,
    CFG_RSV2  = 2'd2,
    CFG_RSV3  = 2'd3
  } cfg_idx_t;

  localparam int OFF_W   = 11;
  localparam int TGT_W   = 23;
  localparam int POS_W   = 24;
  localparam int QDEPTH  = 4;
  localparam int QCNT_W  = 3;

  localparam logic [OFF_W-1:0] MAX_OFFSET = 11'd2000;

  // What one axis lane hands to the merging stage.
  typedef struct packed {
    logic signed [POS_W-1:0] new_pos;
    logic                    new_flag;
    logic                    flip;
    logic signed [POS_W-1:0] travel_pos;
  } lane_res_t;

  // One result request.
  typedef struct packed {
    logic                    pass_through;
    logic                    is_travel;
    logic                    has_x;
    logic                    has_y;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic                    last;
  } res_t;

endpackage

FILE: sv/bc_axis_lane.sv
module bc_axis_lane
  import bc_pkg::*;
(
  input  logic                    present,
  input  logic signed [TGT_W-1:0] target,
  input  logic        [OFF_W-1:0] offset,
  input  logic signed [POS_W-1:0] pos,
  input  logic                    flag,
  output lane_res_t               res
);

  logic signed [POS_W:0]   t_ext;
  logic signed [POS_W:0]   p_ext;
  logic signed [POS_W:0]   o_ext;
  logic signed [POS_W:0]   sum;
  logic signed [POS_W:0]   trav;
  logic signed [POS_W-1:0] t_pos;

  // Compare and add at one bit above the position width so nothing wraps.
  always_comb begin
    t_ext = {{(POS_W+1-TGT_W){target[TGT_W-1]}}, target};
    p_ext = {pos[POS_W-1], pos};
    o_ext = {{(POS_W+1-OFF_W){1'b0}}, offset};
    sum   = t_ext + o_ext;
    t_pos = t_ext[POS_W-1:0];
    trav  = flag ? (p_ext - o_ext) : (p_ext + o_ext);
  end

  // Direction decision for this axis.
  always_comb begin
    res.new_pos    = pos;
    res.new_flag   = flag;
    res.flip       = 1'b0;
    res.travel_pos = pos;
    if (present) begin
      if (offset == '0) begin
        res.new_pos  = t_pos;
        res.new_flag = 1'b0;
      end else if (flag) begin
        if (sum >= p_ext) begin
          res.new_pos  = sum[POS_W-1:0];
          res.new_flag = 1'b1;
        end else begin
          res.new_pos  = t_pos;
          res.new_flag = 1'b0;
          res.flip     = 1'b1;
        end
      end else if (t_ext > p_ext) begin
        res.new_pos  = sum[POS_W-1:0];
        res.new_flag = 1'b1;
        res.flip     = 1'b1;
      end else begin
        res.new_pos  = t_pos;
        res.new_flag = 1'b0;
      end
      if (res.flip) begin
        res.travel_pos = trav[POS_W-1:0];
      end
    end
  end

endmodule

FILE: sv/bc_merge.sv
module bc_merge
  import bc_pkg::*;
(
  input  logic       move,
  input  logic       has_x,
  input  logic       has_y,
  input  logic       extruding,
  input  lane_res_t  lane_x,
  input  lane_res_t  lane_y,
  output res_t       res0,
  output res_t       res1,
  output logic [1:0] n_res
);

  res_t pass_res;
  res_t trav_res;
  res_t fin_res;
  logic need_travel;

  // Build the candidate results from what both lanes found.
  always_comb begin
    pass_res              = '0;
    pass_res.pass_through = 1'b1;
    pass_res.last         = 1'b1;

    trav_res              = '0;
    trav_res.is_travel    = 1'b1;
    trav_res.has_x        = has_x;
    trav_res.has_y        = has_y;
    trav_res.x            = has_x ? lane_x.travel_pos : '0;
    trav_res.y            = has_y ? lane_y.travel_pos : '0;

    fin_res               = '0;
    fin_res.has_x         = has_x;
    fin_res.has_y         = has_y;
    fin_res.x             = has_x ? lane_x.new_pos : '0;
    fin_res.y             = has_y ? lane_y.new_pos : '0;
    fin_res.last          = 1'b1;

    need_travel = (lane_x.flip | lane_y.flip) & extruding;
  end

  // Select which results go out and how many.
  always_comb begin
    res0  = pass_res;
    res1  = fin_res;
    n_res = 2'd1;
    if (move) begin
      if (need_travel) begin
        res0  = trav_res;
        n_res = 2'd2;
      end else begin
        res0 = fin_res;
      end
    end
  end

endmodule

FILE: sv/bc_out_queue.sv
module bc_out_queue
  import bc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] push_n,
  input  res_t       push0,
  input  res_t       push1,
  output logic       space,
  output logic       out_valid,
  input  logic       out_ready,
  output res_t       head
);

  res_t              q_r   [QDEPTH];
  res_t              q_nxt [QDEPTH];
  logic [QCNT_W-1:0] cnt_r;
  logic [QCNT_W-1:0] cnt_nxt;
  logic [QCNT_W-1:0] cnt_pop;
  logic              pop;

  assign out_valid = (cnt_r != '0);
  assign head      = q_r[0];
  assign space     = (cnt_r <= QCNT_W'(QDEPTH - 2));
  assign pop       = out_valid & out_ready;

  // Shift out the head on a pop, then append up to two new results.
  always_comb begin
    cnt_pop = cnt_r - {{(QCNT_W-1){1'b0}}, pop};
    for (int i = 0; i < QDEPTH - 1; i++) begin
      q_nxt[i] = pop ? q_r[i+1] : q_r[i];
    end
    q_nxt[QDEPTH-1] = q_r[QDEPTH-1];
    for (int i = 0; i < QDEPTH; i++) begin
      if (push_n != 2'd0 && QCNT_W'(i) == cnt_pop) begin
        q_nxt[i] = push0;
      end else if (push_n == 2'd2 && QCNT_W'(i) == cnt_pop + 1'b1) begin
        q_nxt[i] = push1;
      end
    end
    cnt_nxt = cnt_pop + {{(QCNT_W-2){1'b0}}, push_n};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("result queue holds more entries than it has");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push_n != 2'd0 |-> space)
    else $error("result pushed without room in the queue");
`endif

endmodule

FILE: sv/xy_backlash_compensator_core.sv
// A result is registered in the result queue when its request is accepted and leaves from the queue head.
// Throughput: one request per cycle while the result queue has room for two more results.
// A move that needs an inserted travel move yields two results, which drain one per cycle
// while out_ready is high, through the single output port of a four-entry result queue.
// Reset (rst_n, synchronous, active low) clears offsets, mode flags, positions,
// compensation flags and the queue.
module xy_backlash_compensator_core
  import bc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [1:0]              cfg_index,
  input  logic [OFF_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_kind,
  input  logic                    in_has_x,
  input  logic                    in_has_y,
  input  logic signed [TGT_W-1:0] in_x_target,
  input  logic signed [TGT_W-1:0] in_y_target,
  input  logic                    in_extruding,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_pass_through,
  output logic                    out_is_travel,
  output logic                    out_has_x,
  output logic                    out_has_y,
  output logic signed [POS_W-1:0] out_x,
  output logic signed [POS_W-1:0] out_y,
  output logic                    out_last
);

  logic [OFF_W-1:0]        x_off_r, y_off_r;
  logic [OFF_W-1:0]        cfg_sat;
  logic                    abs_seen_r, abs_seen_nxt;
  logic                    rel_r, rel_nxt;
  logic signed [POS_W-1:0] pos_x_r, pos_x_nxt;
  logic signed [POS_W-1:0] pos_y_r, pos_y_nxt;
  logic                    flag_x_r, flag_x_nxt;
  logic                    flag_y_r, flag_y_nxt;
  logic                    acc;
  logic                    move;
  lane_res_t               lane_x, lane_y;
  res_t                    res0, res1, head;
  logic [1:0]              n_res;
  logic [1:0]              push_n;
  logic                    space;

  assign cfg_ready = 1'b1;
  assign in_ready  = space;
  assign acc       = in_valid & in_ready;
  assign cfg_sat   = (cfg_data > MAX_OFFSET) ? MAX_OFFSET : cfg_data;

  // Offsets are saturated as they are written.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_off_r <= '0;
      y_off_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_X_OFF: x_off_r <= cfg_sat;
        CFG_Y_OFF: y_off_r <= cfg_sat;
        default: ;
      endcase
    end
  end

  // A move is compensated only in absolute mode once absolute mode has been seen.
  assign move = (kind_t'(in_kind) == KIND_MOVE) && abs_seen_r && !rel_r &&
                (in_has_x || in_has_y);

  bc_axis_lane u_lane_x (
    .present (in_has_x),
    .target  (in_x_target),
    .offset  (x_off_r),
    .pos     (pos_x_r),
    .flag    (flag_x_r),
    .res     (lane_x)
  );

  bc_axis_lane u_lane_y (
    .present (in_has_y),
    .target  (in_y_target),
    .offset  (y_off_r),
    .pos     (pos_y_r),
    .flag    (flag_y_r),
    .res     (lane_y)
  );

  bc_merge u_merge (
    .move      (move),
    .has_x     (in_has_x),
    .has_y     (in_has_y),
    .extruding (in_extruding),
    .lane_x    (lane_x),
    .lane_y    (lane_y),
    .res0      (res0),
    .res1      (res1),
    .n_res     (n_res)
  );

  // Mode flags and axis state advance with each accepted request.
  always_comb begin
    abs_seen_nxt = abs_seen_r;
    rel_nxt      = rel_r;
    pos_x_nxt    = pos_x_r;
    pos_y_nxt    = pos_y_r;
    flag_x_nxt   = flag_x_r;
    flag_y_nxt   = flag_y_r;
    if (acc) begin
      case (kind_t'(in_kind))
        KIND_ABS: begin
          abs_seen_nxt = 1'b1;
          rel_nxt      = 1'b0;
        end
        KIND_REL: rel_nxt = 1'b1;
        default: ;
      endcase
      if (move) begin
        pos_x_nxt  = lane_x.new_pos;
        pos_y_nxt  = lane_y.new_pos;
        flag_x_nxt = lane_x.new_flag;
        flag_y_nxt = lane_y.new_flag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      abs_seen_r <= 1'b0;
      rel_r      <= 1'b0;
      pos_x_r    <= '0;
      pos_y_r    <= '0;
      flag_x_r   <= 1'b0;
      flag_y_r   <= 1'b0;
    end else begin
      abs_seen_r <= abs_seen_nxt;
      rel_r      <= rel_nxt;
      pos_x_r    <= pos_x_nxt;
      pos_y_r    <= pos_y_nxt;
      flag_x_r   <= flag_x_nxt;
      flag_y_r   <= flag_y_nxt;
    end
  end

  assign push_n = acc ? n_res : 2'd0;

  bc_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .push0     (res0),
    .push1     (res1),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_pass_through = head.pass_through;
  assign out_is_travel    = head.is_travel;
  assign out_has_x        = head.has_x;
  assign out_has_y        = head.has_y;
  assign out_x            = head.x;
  assign out_y            = head.y;
  assign out_last         = head.last;

`ifndef SYNTHESIS
  a_travel_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_travel |-> !out_last && !out_pass_through)
    else $error("inserted travel move marked as last or pass-through");

  a_abs_mode: assert property (@(posedge clk) disable iff (!rst_n)
    acc && kind_t'(in_kind) == KIND_ABS |=> abs_seen_r && !rel_r)
    else $error("absolute-mode command did not set the mode flags");

  a_off_sat: assert property (@(posedge clk) disable iff (!rst_n)
    x_off_r <= MAX_OFFSET && y_off_r <= MAX_OFFSET)
    else $error("backlash offset above its saturation limit");
`endif

endmodule

FILE: dv/tb_xy_backlash_compensator_core.sv
module tb_xy_backlash_compensator_core;
  import bc_pkg::*;

  localparam int TGT_MAX     = 4194303;
  localparam int TGT_MIN     = -4194304;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 80;

  // One decoded motion command as it is offered to the block.
  typedef struct packed {
    kind_t                   kind;
    logic                    has_x;
    logic                    has_y;
    logic signed [TGT_W-1:0] x_target;
    logic signed [TGT_W-1:0] y_target;
    logic                    extruding;
  } cmd_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [1:0]              cfg_index = '0;
  logic [OFF_W-1:0]        cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [1:0]              in_kind = '0;
  logic                    in_has_x = 1'b0;
  logic                    in_has_y = 1'b0;
  logic signed [TGT_W-1:0] in_x_target = '0;
  logic signed [TGT_W-1:0] in_y_target = '0;
  logic                    in_extruding = 1'b0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic                    out_pass_through;
  logic                    out_is_travel;
  logic                    out_has_x;
  logic                    out_has_y;
  logic signed [POS_W-1:0] out_x;
  logic signed [POS_W-1:0] out_y;
  logic                    out_last;

  // Offsets and machine state as the block should hold them.
  logic [OFF_W-1:0]        x_off_um = '0;
  logic [OFF_W-1:0]        y_off_um = '0;
  logic                    abs_mode_seen = 1'b0;
  logic                    rel_mode_on = 1'b0;
  logic signed [POS_W-1:0] last_x = '0;
  logic signed [POS_W-1:0] last_y = '0;
  logic                    x_comp_on = 1'b0;
  logic                    y_comp_on = 1'b0;

  cmd_t cmd_queue[$];
  cmd_t cur_cmd;
  res_t expected_moves[$];
  res_t seen_res;
  res_t want_res;

  int   mismatches = 0;
  int   stall_cycles = 0;
  int   send_idle_pct = 26;
  int   recv_idle_pct = 77;
  logic hold_request = 1'b0;
  logic hold_taken = 1'b0;
  int   hold_left = 0;
  int   gen_x = 0;
  int   gen_y = 0;

  xy_backlash_compensator_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_has_x         (in_has_x),
    .in_has_y         (in_has_y),
    .in_x_target      (in_x_target),
    .in_y_target      (in_y_target),
    .in_extruding     (in_extruding),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pass_through (out_pass_through),
    .out_is_travel    (out_is_travel),
    .out_has_x        (out_has_x),
    .out_has_y        (out_has_y),
    .out_x            (out_x),
    .out_y            (out_y),
    .out_last         (out_last)
  );

  always #6 clk = ~clk;

  // Reset is held low at the start of the run only, then released.
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  // New position and flag of one axis; returns high when the axis changes direction.
  function automatic logic axis_compensate(input int target, input int offset, input int prev,
                                           input logic applied, output int next_pos,
                                           output logic next_applied);
    if (offset == 0) begin
      next_pos = target;
      next_applied = 1'b0;
      return 1'b0;
    end
    if (applied) begin
      if (target + offset >= prev) begin
        next_pos = target + offset;
        next_applied = 1'b1;
        return 1'b0;
      end
      next_pos = target;
      next_applied = 1'b0;
      return 1'b1;
    end
    if (target > prev) begin
      next_pos = target + offset;
      next_applied = 1'b1;
      return 1'b1;
    end
    next_pos = target;
    next_applied = 1'b0;
    return 1'b0;
  endfunction

  // Works out the results of one accepted command and updates the machine state.
  task automatic compensate_command(input cmd_t c);
    int   tx, ty, ox, oy, px, py, nx, ny, vx, vy;
    logic nfx, nfy, flip_x, flip_y;
    res_t r;
    tx = c.x_target;
    ty = c.y_target;
    ox = x_off_um;
    oy = y_off_um;
    px = last_x;
    py = last_y;
    nx = px;
    ny = py;
    nfx = x_comp_on;
    nfy = y_comp_on;
    flip_x = 1'b0;
    flip_y = 1'b0;

    if (c.kind == KIND_ABS) begin
      abs_mode_seen = 1'b1;
      rel_mode_on = 1'b0;
    end else if (c.kind == KIND_REL) begin
      rel_mode_on = 1'b1;
    end

    // Anything but an absolute move with at least one axis goes through untouched.
    if (c.kind != KIND_MOVE || !abs_mode_seen || rel_mode_on || (!c.has_x && !c.has_y)) begin
      r = '0;
      r.pass_through = 1'b1;
      r.last = 1'b1;
      expected_moves.push_back(r);
      return;
    end

    if (c.has_x) flip_x = axis_compensate(tx, ox, px, x_comp_on, nx, nfx);
    if (c.has_y) flip_y = axis_compensate(ty, oy, py, y_comp_on, ny, nfy);

    // A reversal during extrusion first takes up the slack with a travel move.
    if ((flip_x || flip_y) && c.extruding) begin
      vx = px;
      vy = py;
      if (flip_x) vx = x_comp_on ? px - ox : px + ox;
      if (flip_y) vy = y_comp_on ? py - oy : py + oy;
      r = '0;
      r.is_travel = 1'b1;
      r.has_x = c.has_x;
      r.has_y = c.has_y;
      if (c.has_x) r.x = POS_W'(vx);
      if (c.has_y) r.y = POS_W'(vy);
      expected_moves.push_back(r);
    end

    r = '0;
    r.has_x = c.has_x;
    r.has_y = c.has_y;
    if (c.has_x) r.x = POS_W'(nx);
    if (c.has_y) r.y = POS_W'(ny);
    r.last = 1'b1;
    expected_moves.push_back(r);

    last_x = POS_W'(nx);
    last_y = POS_W'(ny);
    x_comp_on = nfx;
    y_comp_on = nfy;
  endtask

  // Offsets above the maximum are clipped when written; reserved indexes are ignored.
  task automatic write_reg(input cfg_idx_t idx, input logic [OFF_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_X_OFF: x_off_um = (val > MAX_OFFSET) ? MAX_OFFSET : val;
      CFG_Y_OFF: y_off_um = (val > MAX_OFFSET) ? MAX_OFFSET : val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // Waits until every request has gone in and every result has come back.
  task automatic wait_drained();
    while (cmd_queue.size() != 0 || in_valid || expected_moves.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic cmd_t make_cmd(input kind_t kind, input logic hx, input logic hy,
                                    input int x, input int y, input logic ext);
    cmd_t c;
    c.kind = kind;
    c.has_x = hx;
    c.has_y = hy;
    c.x_target = TGT_W'(x);
    c.y_target = TGT_W'(y);
    c.extruding = ext;
    return c;
  endfunction

  // Targets mostly wander near the previous one so that reversals and ties are common.
  function automatic int next_target(input int prev);
    int t;
    int r;
    r = $urandom_range(99);
    if (r < 20) begin
      t = prev;
    end else if (r < 35) begin
      t = $urandom_range(1) ? prev + 1 : prev - 1;
    end else if (r < 75) begin
      t = prev + int'($urandom_range(5000)) - 2500;
    end else if (r < 90) begin
      t = int'($urandom_range(8388607)) + TGT_MIN;
    end else begin
      case ($urandom_range(3))
        0: t = TGT_MAX;
        1: t = TGT_MIN;
        2: t = 0;
        default: t = -1;
      endcase
    end
    if (t > TGT_MAX) t = TGT_MAX;
    if (t < TGT_MIN) t = TGT_MIN;
    return t;
  endfunction

  function automatic cmd_t random_command();
    cmd_t c;
    int   pick;
    int   sel;
    pick = $urandom_range(99);
    if (pick < 8) c.kind = KIND_ABS;
    else if (pick < 11) c.kind = KIND_REL;
    else if (pick < 90) c.kind = KIND_MOVE;
    else c.kind = KIND_OTHER;
    sel = $urandom_range(19);
    c.has_x = (sel < 14);
    c.has_y = (sel < 10) || (sel >= 14 && sel < 18);
    c.x_target = TGT_W'(next_target(gen_x));
    c.y_target = TGT_W'(next_target(gen_y));
    c.extruding = ($urandom_range(9) < 6);
    if (c.kind == KIND_MOVE && c.has_x) gen_x = c.x_target;
    if (c.kind == KIND_MOVE && c.has_y) gen_y = c.y_target;
    return c;
  endfunction

  // Request driver: offers the next pending command, idling at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        compensate_command(cur_cmd);
      end
      if (!in_valid || in_ready) begin
        if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_cmd = cmd_queue.pop_front();
          in_kind      <= cur_cmd.kind;
          in_has_x     <= cur_cmd.has_x;
          in_has_y     <= cur_cmd.has_y;
          in_x_target  <= cur_cmd.x_target;
          in_y_target  <= cur_cmd.y_target;
          in_extruding <= cur_cmd.extruding;
          in_valid     <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each result against the oldest expectation and throttles ready.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        seen_res.pass_through = out_pass_through;
        seen_res.is_travel    = out_is_travel;
        seen_res.has_x        = out_has_x;
        seen_res.has_y        = out_has_y;
        seen_res.x            = out_x;
        seen_res.y            = out_y;
        seen_res.last         = out_last;
        if (expected_moves.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with no expectation pending: ", $time,
                     "pt=%0b tr=%0b hx=%0b hy=%0b x=%0d y=%0d last=%0b",
                     seen_res.pass_through, seen_res.is_travel, seen_res.has_x,
                     seen_res.has_y, seen_res.x, seen_res.y, seen_res.last);
        end else begin
          want_res = expected_moves.pop_front();
          if (seen_res !== want_res) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch, expected pt=%0b tr=%0b hx=%0b hy=%0b ",
                       $time, want_res.pass_through, want_res.is_travel, want_res.has_x,
                       want_res.has_y,
                       "x=%0d y=%0d last=%0b, got pt=%0b tr=%0b hx=%0b hy=%0b ",
                       want_res.x, want_res.y, want_res.last,
                       seen_res.pass_through, seen_res.is_travel, seen_res.has_x,
                       seen_res.has_y,
                       "x=%0d y=%0d last=%0b",
                       seen_res.x, seen_res.y, seen_res.last);
          end
        end
      end
      // A long hold-off fills the block so that it has to stall its input.
      if (hold_request && !hold_taken) begin
        hold_left = HOLD_CYCLES;
        hold_taken = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: ends the run when nothing has been accepted for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Stimulus sequence: directed commands, then random phases under varying offsets.
  initial begin
    logic [OFF_W-1:0] ox;
    logic [OFF_W-1:0] oy;
    repeat (6) @(posedge clk);

    // An X offset beyond the maximum is clipped; reserved registers take writes too.
    write_reg(CFG_X_OFF, 11'h7FF);
    write_reg(CFG_Y_OFF, 11'd150);
    write_reg(CFG_RSV2, 11'h7FF);
    write_reg(CFG_RSV3, 11'd0);
    @(negedge clk);

    // Moves before any absolute-mode command pass through.
    cmd_queue.push_back(make_cmd(KIND_MOVE, 1'b1, 1'b1, 1000, 1000, 1'b1));
    cmd_queue.push_back(make_cmd(KIND_OTHER, 1'b1, 1'b1, 5, 5, 1'b1));
    cmd_queue.push_back(make_cmd(KIND_ABS, 1'b0, 1'b0, 0, 0, 1'b0));
    // Both axes turn positive without extrusion, so no travel move.
    cmd_queue.push_back(make_cmd(KIND_MOVE, 1'b1, 1'b1, 1000, 1000, 1'b0));
    // X turns back while extruding; Y stays put with its offset kept.
    cmd_queue.push_back(make_cmd(KIND_MOVE, 1'b1, 1'b1, 500, 1000, 1'b1));
    cmd_queue.push_back(make_cmd(KIND_MOVE, 1'b1, 1'b0, 500, 0, 1'b1));
    cmd_queue.push_back(make_cmd(KIND_MOVE, 1'b1, 1'b0, 501, 0, 1'b1));
    cmd_queue.push_back(make_cmd(KIND_MOVE, 1'b0, 1'b1, 0, 999, 1'b1));
    // A move with neither axis passes through.
    cmd_queue.push_back(make_cmd(KIND_MOVE, 1'b0, 1'b0, 7, 7, 1'b1));
    // Extremes of the target range in both directions.
    cmd_queue.push_back(make_cmd(KIND_MOVE, 1'b1, 1'b1, TGT_MAX, TGT_MIN, 1'b1));
    cmd_queue.push_back(make_cmd(KIND_MOVE, 1'b1, 1'b1, TGT_MIN, TGT_MAX, 1'b1));
    cmd_queue.push_back(make_cmd(KIND_MOVE, 1'b1, 1'b1, TGT_MIN, TGT_MAX, 1'b0));
    cmd_queue.push_back(make_cmd(KIND_MOVE, 1'b1, 1'b1, TGT_MAX, TGT_MAX, 1'b0));
    // Relative mode passes everything through until absolute mode returns.
    cmd_queue.push_back(make_cmd(KIND_REL, 1'b1, 1'b0, 3, 3, 1'b0));
    cmd_queue.push_back(make_cmd(KIND_MOVE, 1'b1, 1'b1, 100, 100, 1'b1));
    cmd_queue.push_back(make_cmd(KIND_OTHER, 1'b0, 1'b1, -3, -3, 1'b0));
    cmd_queue.push_back(make_cmd(KIND_ABS, 1'b1, 1'b1, 3, 3, 1'b1));
    cmd_queue.push_back(make_cmd(KIND_MOVE, 1'b1, 1'b1, -1, 0, 1'b1));
    cmd_queue.push_back(make_cmd(KIND_MOVE, 1'b1, 1'b1, 0, -1, 1'b1));
    cmd_queue.push_back(make_cmd(KIND_OTHER, 1'b1, 1'b1, 9, 9, 1'b1));
    cmd_queue.push_back(make_cmd(KIND_MOVE, 1'b0, 1'b1, 0, -1, 1'b1));
    cmd_queue.push_back(make_cmd(KIND_MOVE, 1'b1, 1'b0, -2001, 0, 1'b1));
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin ox = 11'd0;    oy = 11'd0;    end
        1: begin ox = 11'd2000; oy = 11'd1;    end
        2: begin ox = 11'd1;    oy = 11'd2000; end
        3: begin ox = 11'd737;  oy = 11'd0;    end
        4: begin ox = 11'h7FF;  oy = 11'd2000; end
        default: begin ox = 11'd0; oy = 11'd1999; end
      endcase
      write_reg(CFG_X_OFF, ox);
      write_reg(CFG_Y_OFF, oy);
      @(negedge clk);
      if (ph == 2) begin
        send_idle_pct = 77;
        recv_idle_pct = 26;
      end
      if (ph == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request = 1'b1;
      end
      repeat (300) cmd_queue.push_back(random_command());
      wait_drained();
    end

    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
